### sv/rah_pkg.sv
// Shared types, seeds and helper function of the rotate-add word hash.
package rah_pkg;

  // Seed values of the lanes and mixes after reset and after each hash.
  localparam logic [63:0] RST_A   = 64'd1;
  localparam logic [63:0] RST_B   = 64'd11;
  localparam logic [63:0] RST_C   = 64'd111;
  localparam logic [63:0] RST_D   = 64'd1111;
  localparam logic [63:0] RST_MIX = 64'd1111111111;
  localparam logic [63:0] RST_OFS = 64'd111111111;

  // Queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  // One command handed from the front to the back.
  typedef struct packed {
    logic             do_group;  // run a complete 32-byte group
    logic             do_final;  // then finish the message
    logic [3:0][63:0] words;     // group words, or the remaining words
    logic [63:0]      sum;       // sum of the four group words
    logic [4:0]       rem_bytes; // bytes left after the last group
    logic [63:0]      msg_len;   // message length in bytes
  } cmd_t;

  // Sequencer of the back part.
  typedef enum logic [4:0] {
    B_IDLE,
    B_GRP1,
    B_GRP2,
    B_FOLD1,
    B_FOLD2,
    B_S16A,
    B_S16B,
    B_S8A,
    B_S8B,
    B_TAIL,
    B_L1,
    B_L23,
    B_L45,
    B_L6,
    B_L78,
    B_L9,
    B_L1011,
    B_L12,
    B_DONE
  } back_state_t;

  // Rotate left by a nonzero constant amount.
  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] s);
    logic [6:0] rs;
    rs = 7'd64 - {1'b0, s};
    return (x << s) | (x >> rs);
  endfunction

endpackage

### sv/rah_front.sv
// Front part: takes words, buffers pending words and issues group and finish commands.
module rah_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       data_word,
  input  logic [3:0]        byte_count,
  input  logic              last_word,
  output logic              push,
  output rah_pkg::cmd_t     cmd,
  input  logic              q_ready
);

  logic [63:0] pend [3];
  logic [1:0]  pcnt;
  logic [63:0] psum;
  logic [63:0] length;

  logic        accept;
  logic [3:0]  bc_c;
  logic [63:0] word_m;
  logic [63:0] len_next;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Clamp the byte count of the last word and clear bytes above it.
  always_comb begin
    bc_c = (byte_count > 4'd8) ? 4'd8 : byte_count;
    word_m = data_word;
    if (last_word) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) >= bc_c) word_m[8*k +: 8] = 8'h00;
      end
    end
    len_next = length + (last_word ? {60'd0, bc_c} : 64'd8);
  end

  // Build the command for the back part.
  always_comb begin
    cmd.do_group = (pcnt == 2'd3) && (!last_word || (bc_c == 4'd8));
    cmd.do_final = last_word;
    cmd.sum      = psum + word_m;
    cmd.msg_len  = len_next;
    if (cmd.do_group) begin
      cmd.words     = {word_m, pend[2], pend[1], pend[0]};
      cmd.rem_bytes = 5'd0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        cmd.words[k] = (2'(k) < pcnt) ? pend[k] : 64'd0;
      end
      cmd.words[3]       = 64'd0;
      cmd.words[pcnt]    = word_m;
      cmd.rem_bytes      = {pcnt, 3'b000} + {1'b0, bc_c};
    end
    push = accept && (last_word || (pcnt == 2'd3));
  end

  // Pending word buffer, partial sum and length counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt   <= 2'd0;
      length <= 64'd0;
    end else if (accept) begin
      if (last_word) begin
        pcnt   <= 2'd0;
        length <= 64'd0;
      end else begin
        length <= len_next;
        if (pcnt == 2'd3) begin
          pcnt <= 2'd0;
        end else begin
          pcnt <= pcnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_word && (pcnt != 2'd3)) begin
      pend[pcnt] <= data_word;
      psum       <= (pcnt == 2'd0) ? data_word : psum + data_word;
    end
  end

endmodule

### sv/rah_queue.sv
// Short command queue between the front and the back.
module rah_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rah_pkg::cmd_t push_cmd,
  output logic          q_ready,
  input  logic          pop,
  output logic          q_valid,
  output rah_pkg::cmd_t pop_cmd
);

  rah_pkg::cmd_t                mem [rah_pkg::QDEPTH];
  logic [rah_pkg::QAW-1:0]      wr_ptr;
  logic [rah_pkg::QAW-1:0]      rd_ptr;
  logic [rah_pkg::QAW:0]        count;
  logic                         do_push;
  logic                         do_pop;

  assign q_ready = (count != (rah_pkg::QAW+1)'(rah_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign pop_cmd = mem[rd_ptr];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (rah_pkg::QAW+1)'(rah_pkg::QDEPTH))
    else $error("command queue count above its depth");
`endif

endmodule

### sv/rah_back.sv
// Back part: runs group updates and the finishing sequence, holds the result register.
module rah_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rah_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   hash_value
);

  rah_pkg::back_state_t state, state_next;

  logic [63:0] lane_a, lane_b, lane_c, lane_d, mix, ofs;
  logic [63:0] lane_a_next, lane_b_next, lane_c_next, lane_d_next, mix_next, ofs_next;
  logic        gseen, gseen_next;
  logic [63:0] lgs, lgs_next;
  logic [63:0] tmp, tmp_next;
  logic [4:0]  rr, rr_next;
  logic [1:0]  jj, jj_next;
  rah_pkg::cmd_t cur;

  logic [63:0] wj;
  logic        out_load;
  logic [63:0] tail_lo;
  logic [63:0] tail_hi;

  // Next step once the fold is done, from the bytes still left.
  function automatic rah_pkg::back_state_t step_after(input logic [4:0] r);
    if (r >= 5'd16) return rah_pkg::B_S16A;
    else if (r >= 5'd8) return rah_pkg::B_S8A;
    else if (r != 5'd0) return rah_pkg::B_TAIL;
    else return rah_pkg::B_L1;
  endfunction

  assign pop      = (state == rah_pkg::B_IDLE) && q_valid;
  assign wj       = cur.words[jj];
  assign out_load = (state == rah_pkg::B_DONE) && (!out_valid || out_ready);

  // Tail bytes of the current word.
  always_comb begin
    tail_lo = {56'd0, wj[7:0]};
    if (rr[2:0] >= 3'd2) tail_lo[15:8] = wj[15:8];
    if (rr[2:0] >= 3'd3) tail_lo[23:16] = wj[23:16];
    tail_hi = {56'd0, wj[39:32]};
    if (rr[2:0] >= 3'd6) tail_hi[15:8] = wj[47:40];
    if (rr[2:0] >= 3'd7) tail_hi[23:16] = wj[55:48];
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      rah_pkg::B_IDLE: begin
        if (q_valid) state_next = q_cmd.do_group ? rah_pkg::B_GRP1 : rah_pkg::B_FOLD1;
      end
      rah_pkg::B_GRP1:  state_next = rah_pkg::B_GRP2;
      rah_pkg::B_GRP2:  state_next = cur.do_final ? rah_pkg::B_FOLD1 : rah_pkg::B_IDLE;
      rah_pkg::B_FOLD1: state_next = gseen ? rah_pkg::B_FOLD2 : step_after(rr);
      rah_pkg::B_FOLD2: state_next = step_after(rr);
      rah_pkg::B_S16A:  state_next = rah_pkg::B_S16B;
      rah_pkg::B_S16B:  state_next = step_after(rr - 5'd16);
      rah_pkg::B_S8A:   state_next = rah_pkg::B_S8B;
      rah_pkg::B_S8B:   state_next = (rr != 5'd8) ? rah_pkg::B_TAIL : rah_pkg::B_L1;
      rah_pkg::B_TAIL:  state_next = rah_pkg::B_L1;
      rah_pkg::B_L1:    state_next = rah_pkg::B_L23;
      rah_pkg::B_L23:   state_next = rah_pkg::B_L45;
      rah_pkg::B_L45:   state_next = rah_pkg::B_L6;
      rah_pkg::B_L6:    state_next = rah_pkg::B_L78;
      rah_pkg::B_L78:   state_next = rah_pkg::B_L9;
      rah_pkg::B_L9:    state_next = rah_pkg::B_L1011;
      rah_pkg::B_L1011: state_next = rah_pkg::B_L12;
      rah_pkg::B_L12:   state_next = rah_pkg::B_DONE;
      rah_pkg::B_DONE:  state_next = out_load ? rah_pkg::B_IDLE : rah_pkg::B_DONE;
      default:          state_next = rah_pkg::B_IDLE;
    endcase
  end

  // Datapath updates of each step.
  always_comb begin
    lane_a_next = lane_a;
    lane_b_next = lane_b;
    lane_c_next = lane_c;
    lane_d_next = lane_d;
    mix_next    = mix;
    ofs_next    = ofs;
    gseen_next  = gseen;
    lgs_next    = lgs;
    tmp_next    = tmp;
    rr_next     = rr;
    jj_next     = jj;
    case (state)
      rah_pkg::B_IDLE: begin
        rr_next = q_cmd.rem_bytes;
        jj_next = 2'd0;
      end
      rah_pkg::B_GRP1: begin
        mix_next    = mix + cur.sum;
        lane_b_next = lane_b + cur.words[2] + rah_pkg::rotl(lane_b, 6'd29);
        lane_c_next = lane_c + cur.words[1] + rah_pkg::rotl(lane_c, 6'd28);
        lane_d_next = lane_d + cur.words[0] + rah_pkg::rotl(lane_d, 6'd27);
        lgs_next    = cur.sum;
        gseen_next  = 1'b1;
      end
      rah_pkg::B_GRP2: begin
        lane_a_next = lane_a + cur.words[3] + rah_pkg::rotl(lane_a, 6'd30) + mix;
      end
      rah_pkg::B_FOLD1: begin
        tmp_next = lgs + lane_a + lane_b;
      end
      rah_pkg::B_FOLD2: begin
        ofs_next = ofs + tmp + lane_c + lane_d;
      end
      rah_pkg::B_S16A: begin
        mix_next = mix + cur.words[0] + cur.words[1];
      end
      rah_pkg::B_S16B: begin
        lane_a_next = lane_a + cur.words[0] + rah_pkg::rotl(lane_a, 6'd30) + mix;
        lane_b_next = lane_b + cur.words[1] + rah_pkg::rotl(lane_b, 6'd28) + mix;
        rr_next     = rr - 5'd16;
        jj_next     = 2'd2;
      end
      rah_pkg::B_S8A: begin
        mix_next = mix + wj + lane_a;
      end
      rah_pkg::B_S8B: begin
        lane_a_next = lane_a + rah_pkg::rotl(wj, 6'd30) + mix;
        rr_next     = rr - 5'd8;
        jj_next     = jj + 2'd1;
      end
      rah_pkg::B_TAIL: begin
        if (rr >= 5'd4) begin
          lane_a_next = lane_a + {32'd0, wj[31:0]} + ofs;
          if (rr != 5'd4) begin
            mix_next    = mix + rah_pkg::rotl(lane_a, 6'd16) + rah_pkg::rotl(lane_b, 6'd20);
            lane_b_next = lane_b + tail_hi;
          end else begin
            mix_next = mix + rah_pkg::rotl(lane_a, 6'd16);
          end
        end else begin
          lane_a_next = lane_a + tail_lo + mix;
        end
      end
      rah_pkg::B_L1: begin
        lane_a_next = lane_a + lane_b + ofs + cur.msg_len;
      end
      rah_pkg::B_L23: begin
        mix_next = mix + rah_pkg::rotl(lane_a, 6'd16) + rah_pkg::rotl(lane_c, 6'd44)
                   + rah_pkg::rotl(lane_d, 6'd22);
        ofs_next = ofs + (rah_pkg::rotl(lane_a, 6'd40) ^ rah_pkg::rotl(lane_b, 6'd36));
      end
      rah_pkg::B_L45: begin
        mix_next    = mix ^ (lane_a + lane_d + rah_pkg::rotl(lane_d, 6'd14));
        lane_b_next = lane_b ^ (ofs + cur.msg_len);
      end
      rah_pkg::B_L6: begin
        ofs_next = ofs + (lane_a ^ (rah_pkg::rotl(lane_b, 6'd36) + mix));
      end
      rah_pkg::B_L78: begin
        lane_a_next = lane_b + lane_d + ofs;
        mix_next    = mix + lane_c + rah_pkg::rotl(lane_d, 6'd22);
      end
      rah_pkg::B_L9: begin
        ofs_next = ofs + (rah_pkg::rotl(lane_a, 6'd40) ^ rah_pkg::rotl(lane_b, 6'd36));
      end
      rah_pkg::B_L1011: begin
        lane_b_next = lane_b ^ (mix + ofs);
        mix_next    = mix + (rah_pkg::rotl(lane_a, 6'd26) ^ lane_d);
      end
      rah_pkg::B_L12: begin
        ofs_next = ofs + (lane_a ^ rah_pkg::rotl(lane_b, 6'd36));
      end
      rah_pkg::B_DONE: begin
        if (out_load) begin
          lane_a_next = rah_pkg::RST_A;
          lane_b_next = rah_pkg::RST_B;
          lane_c_next = rah_pkg::RST_C;
          lane_d_next = rah_pkg::RST_D;
          mix_next    = rah_pkg::RST_MIX;
          ofs_next    = rah_pkg::RST_OFS;
          gseen_next  = 1'b0;
          lgs_next    = 64'd0;
        end
      end
      default: begin
        lgs_next = lgs;
      end
    endcase
  end

  // State and lane registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rah_pkg::B_IDLE;
      lane_a <= rah_pkg::RST_A;
      lane_b <= rah_pkg::RST_B;
      lane_c <= rah_pkg::RST_C;
      lane_d <= rah_pkg::RST_D;
      mix    <= rah_pkg::RST_MIX;
      ofs    <= rah_pkg::RST_OFS;
      gseen  <= 1'b0;
      lgs    <= 64'd0;
    end else begin
      state  <= state_next;
      lane_a <= lane_a_next;
      lane_b <= lane_b_next;
      lane_c <= lane_c_next;
      lane_d <= lane_d_next;
      mix    <= mix_next;
      ofs    <= ofs_next;
      gseen  <= gseen_next;
      lgs    <= lgs_next;
    end
  end

  // Current command and step counters.
  always_ff @(posedge clk) begin
    if (pop) cur <= q_cmd;
    tmp <= tmp_next;
    rr  <= rr_next;
    jj  <= jj_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) hash_value <= mix + ofs;
  end

`ifndef SYNTHESIS
  a_grp_order: assert property (@(posedge clk) disable iff (rst)
    (state == rah_pkg::B_GRP2) |-> ($past(state) == rah_pkg::B_GRP1))
    else $error("second group step without the first");

  a_reseed: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (lane_a == rah_pkg::RST_A) && (mix == rah_pkg::RST_MIX) && !gseen)
    else $error("lanes not reseeded after a hash");

  a_tail_range: assert property (@(posedge clk) disable iff (rst)
    (state == rah_pkg::B_TAIL) |-> ((rr != 5'd0) && (rr < 5'd8)))
    else $error("tail step with an out of range byte count");
`endif

endmodule

### sv/rotate_add_hash64_words.sv
// Throughput: one word per cycle while the queue has room; the back runs a group in GRP1 and GRP2.
// No result for non-last words; the hash follows the last word through the fold, step, tail and
// finishing states of the back part. The finishing sequencer in the back part stalls input once
// the two-entry command queue is full. Reset (rst, synchronous) reseeds all lanes and empties
// the queue; the block takes items in the first cycle after reset.
module rotate_add_hash64_words (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  logic          push;
  rah_pkg::cmd_t push_cmd;
  logic          q_ready;
  logic          q_valid;
  logic          pop;
  rah_pkg::cmd_t pop_cmd;

  rah_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .push       (push),
    .cmd        (push_cmd),
    .q_ready    (q_ready)
  );

  rah_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  rah_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

### tb/rotate_add_hash64_words_tb.sv
// Self-checking testbench of the rotate-add word hash: directed and random messages checked against a local model.
module rotate_add_hash64_words_tb;

  // Idling mix of the two sides during a stretch of the run.
  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_NO_IDLE
  } idle_phase_t;

  // Content of a generated message word.
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } word_fill_t;

  // One message word as offered to the block, with its pacing marks.
  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    idle_phase_t phase;
    logic        wait_idle;  // hold this word back until every hash has come
    logic        hold_sink;  // start a long sink stall when this word is offered
  } msg_word_t;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [63:0] data_word  = '0;
  logic [3:0]  byte_count = '0;
  logic        last_word  = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [63:0] hash_value;

  msg_word_t   message_words[$];
  logic [63:0] expected_hashes[$];
  msg_word_t   offered;
  logic        offering   = 1'b0;
  logic        loading;
  logic        rx_hold_go = 1'b0;
  idle_phase_t run_phase  = PH_SLOW_SINK;
  int          sink_hold_left;
  logic        sink_ready;
  logic [63:0] want;
  int          words_accepted = 0;
  int          words_total;
  int          mismatches = 0;

  // Hash state of the local model.
  logic [63:0] acc_a, acc_b, acc_c, acc_d;
  logic [63:0] mix_sum, ofs_sum, byte_len, group_total;
  logic [63:0] held_words[3];
  int unsigned held_cnt;
  logic        saw_group;

  rotate_add_hash64_words u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  // Rotate left by a nonzero amount.
  function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned s);
    return (x << s) | (x >> (64 - s));
  endfunction

  // Seed values, used after reset and after every hash.
  function automatic void clear_hash_state();
    acc_a       = 64'd1;
    acc_b       = 64'd11;
    acc_c       = 64'd111;
    acc_d       = 64'd1111;
    mix_sum     = 64'd1111111111;
    ofs_sum     = 64'd111111111;
    held_cnt    = 0;
    byte_len    = '0;
    saw_group   = 1'b0;
    group_total = '0;
  endfunction

  // Absorb one complete 32-byte group into the lanes.
  function automatic void absorb_group(input logic [63:0] w0, w1, w2, w3);
    logic [63:0] total;
    total = w0 + w1 + w2 + w3;
    mix_sum += total;
    acc_a += w3 + rol64(acc_a, 30) + mix_sum;
    acc_b += w2 + rol64(acc_b, 29);
    acc_c += w1 + rol64(acc_c, 28);
    acc_d += w0 + rol64(acc_d, 27);
    saw_group   = 1'b1;
    group_total = total;
  endfunction

  // Take one accepted word; on the last word compute the hash and queue it.
  function automatic void absorb_word(input msg_word_t it);
    logic [63:0] w, a, b, c, d, mix, ofs, n, tw;
    logic [63:0] rest[4];
    int unsigned bc, r, j;
    w = it.data;
    if (!it.last) begin
      byte_len += 64'd8;
      if (held_cnt == 3) begin
        absorb_group(held_words[0], held_words[1], held_words[2], w);
        held_cnt = 0;
      end else begin
        held_words[held_cnt] = w;
        held_cnt++;
      end
      return;
    end

    // Clamp the count and drop the bytes above it.
    bc = (it.count > 4'd8) ? 8 : it.count;
    byte_len += 64'(bc);
    if (bc < 8) w &= (64'd1 << (8 * bc)) - 64'd1;

    // A full last word may complete a group, which leaves no tail.
    if (held_cnt == 3 && bc == 8) begin
      absorb_group(held_words[0], held_words[1], held_words[2], w);
      held_cnt = 0;
      bc = 0;
    end
    for (int k = 0; k < 3; k++) rest[k] = (k < held_cnt) ? held_words[k] : 64'd0;
    rest[3] = '0;
    rest[held_cnt] = w;
    r = held_cnt * 8 + bc;

    // Fold the most recent group into the offset mix.
    if (saw_group) ofs_sum += group_total + acc_a + acc_b + acc_c + acc_d;

    a = acc_a;
    b = acc_b;
    c = acc_c;
    d = acc_d;
    mix = mix_sum;
    ofs = ofs_sum;
    n = byte_len;
    j = 0;

    // Sixteen-byte step.
    if (r >= 16) begin
      mix += rest[0] + rest[1];
      a += rest[0] + rol64(a, 30) + mix;
      b += rest[1] + rol64(b, 28) + mix;
      j = 2;
      r -= 16;
    end
    // Eight-byte step.
    if (r >= 8) begin
      tw = rest[j];
      mix += tw + a;
      a += rol64(tw, 30) + mix;
      j++;
      r -= 8;
    end
    // Tail of one to seven bytes.
    if (r != 0) begin
      tw = rest[j];
      if (r >= 4) begin
        mix += rol64(a, 16);
        a += {32'd0, tw[31:0]} + ofs;
        if (r != 4) begin
          mix += rol64(b, 20);
          if (r >= 7) b += {40'd0, tw[55:48], 16'd0};
          if (r >= 6) b += {48'd0, tw[47:40], 8'd0};
          b += {56'd0, tw[39:32]};
        end
      end else begin
        if (r >= 3) a += {40'd0, tw[23:16], 16'd0};
        if (r >= 2) a += {48'd0, tw[15:8], 8'd0};
        a += {56'd0, tw[7:0]} + mix;
      end
    end

    // Fixed finalization.
    a += b + ofs + n;
    mix += rol64(a, 16) + rol64(c, 44) + rol64(d, 22);
    ofs += rol64(a, 40) ^ rol64(b, 36);
    mix ^= a + d + rol64(d, 14);
    b ^= ofs + n;
    ofs += a ^ (rol64(b, 36) + mix);
    a = b + d + ofs;
    mix += c + rol64(d, 22);
    ofs += rol64(a, 40) ^ rol64(b, 36);
    b ^= mix + ofs;
    mix += rol64(a, 26) ^ d;
    ofs += a ^ rol64(b, 36);

    expected_hashes.push_back(mix + ofs);
    clear_hash_state();
  endfunction

  // Percentage of cycles in which a side idles during a phase.
  function automatic int idle_pct(input idle_phase_t ph, input logic is_sink);
    case (ph)
      PH_SLOW_SINK:   return is_sink ? 83 : 7;
      PH_SLOW_SOURCE: return is_sink ? 7 : 83;
      default:        return 0;
    endcase
  endfunction

  // Word content; random words are now and then all ones or all zeros.
  function automatic logic [63:0] pick_word(input word_fill_t fill);
    case (fill)
      FILL_ONES:  return '1;
      FILL_ZEROS: return '0;
      default: begin
        case ($urandom_range(39))
          0:       return '1;
          1:       return '0;
          default: return {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatches++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp_val, $time);
  endtask

  // Queue a message of full body words followed by a last word with the given count.
  task automatic queue_message(input int body_words, input logic [3:0] tail_count,
                               input idle_phase_t ph, input logic wait_idle,
                               input logic hold_sink, input word_fill_t fill);
    msg_word_t it;
    for (int k = 0; k <= body_words; k++) begin
      it.data      = pick_word(fill);
      it.last      = (k == body_words);
      it.count     = it.last ? tail_count : 4'($urandom_range(15));
      it.phase     = ph;
      it.wait_idle = wait_idle && (k == 0);
      it.hold_sink = hold_sink && (k == 0);
      message_words.push_back(it);
    end
  endtask

  // Queue random messages, mostly short, until about n_items words are queued.
  task automatic queue_random(input idle_phase_t ph, input int n_items, input logic wait_first);
    int added;
    int body;
    logic [3:0] tc;
    logic first;
    added = 0;
    first = wait_first;
    while (added < n_items) begin
      case ($urandom_range(9))
        0:       body = $urandom_range(40, 16);
        1, 2, 3: body = $urandom_range(3, 0);
        default: body = $urandom_range(12, 0);
      endcase
      tc = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      queue_message(body, tc, ph, first, 1'b0, FILL_RANDOM);
      first = 1'b0;
      added += body + 1;
    end
  endtask

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Reset is held at the start of the run only.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit.
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Driver: offers queued words, predicting each hash as its words are accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      rx_hold_go <= 1'b0;
      offering = 1'b0;
    end else begin
      loading = 1'b0;
      if (in_valid && in_ready) begin
        absorb_word(offered);
        words_accepted++;
        offering = 1'b0;
      end
      if (!offering && message_words.size() != 0) begin
        offered = message_words[0];
        if (!(offered.wait_idle && expected_hashes.size() != 0) &&
            $urandom_range(99) >= idle_pct(offered.phase, 1'b0)) begin
          void'(message_words.pop_front());
          offering = 1'b1;
          loading  = 1'b1;
          data_word  <= offered.data;
          byte_count <= offered.count;
          last_word  <= offered.last;
          run_phase  <= offered.phase;
        end
      end
      in_valid   <= offering;
      rx_hold_go <= loading && offered.hold_sink;
    end
  end

  // Monitor: checks each hash against the oldest prediction and paces out_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("hash with no message pending", hash_value, '0);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) report_mismatch("hash_value", hash_value, want);
        end
      end
      if (rx_hold_go) sink_hold_left = HOLD_CYCLES;
      if (sink_hold_left != 0) begin
        sink_hold_left--;
        sink_ready = 1'b0;
      end else begin
        sink_ready = ($urandom_range(99) >= idle_pct(run_phase, 1'b1));
      end
      out_ready <= sink_ready;
    end
  end

  // Stimulus and end of run.
  initial begin
    clear_hash_state();

    // Empty message with all data bits set, then one byte.
    queue_message(0, 4'd0, PH_SLOW_SINK, 1'b0, 1'b0, FILL_ONES);
    queue_message(0, 4'd1, PH_SLOW_SINK, 1'b0, 1'b0, FILL_ONES);
    // A count above eight is taken as eight; a full single word of zeros.
    queue_message(0, 4'd15, PH_SLOW_SINK, 1'b0, 1'b0, FILL_ONES);
    queue_message(0, 4'd8, PH_SLOW_SINK, 1'b0, 1'b0, FILL_ZEROS);
    // The last word completes a group.
    queue_message(3, 4'd8, PH_SLOW_SINK, 1'b0, 1'b0, FILL_ONES);
    // Sixteen- and eight-byte steps with an empty last word.
    queue_message(3, 4'd0, PH_SLOW_SINK, 1'b0, 1'b0, FILL_ZEROS);
    // Sixteen-byte step and a seven-byte tail.
    queue_message(2, 4'd7, PH_SLOW_SINK, 1'b0, 1'b0, FILL_RANDOM);
    // Eight-byte step and a four-byte tail.
    queue_message(1, 4'd4, PH_SLOW_SINK, 1'b0, 1'b0, FILL_RANDOM);
    // A whole group, then a three-byte tail.
    queue_message(4, 4'd3, PH_SLOW_SINK, 1'b0, 1'b0, FILL_RANDOM);

    queue_random(PH_SLOW_SINK, 520, 1'b0);
    queue_random(PH_SLOW_SOURCE, 560, 1'b1);

    // Burst of one-word messages against a long sink stall, so the block backs up.
    queue_message(0, 4'd8, PH_NO_IDLE, 1'b1, 1'b1, FILL_RANDOM);
    for (int k = 0; k < 39; k++)
      queue_message(0, 4'($urandom_range(8)), PH_NO_IDLE, 1'b0, 1'b0, FILL_RANDOM);
    queue_random(PH_NO_IDLE, 520, 1'b1);

    words_total = message_words.size();
    while (words_accepted != words_total || expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
